/* sv/r2a_pkg.sv */
package r2a_pkg;

  // One input transaction: word, signed-mode flag, radix.
  typedef struct packed {
    logic [31:0] value;
    logic        is_signed;
    logic [4:0]  base;
  } in_item_t;

  // One result transaction: one ASCII character and its last flag.
  typedef struct packed {
    logic [6:0] digit_code;
    logic       last;
  } out_item_t;

  localparam logic [4:0] BASE_MIN      = 5'd2;
  localparam logic [4:0] BASE_MAX      = 5'd16;
  localparam logic [3:0] DIGIT_TEN     = 4'd10;
  localparam logic [6:0] CH_MINUS      = 7'd45;  // '-'
  localparam logic [6:0] CH_ZERO       = 7'd48;  // '0'
  localparam logic [6:0] CH_LETTER_OFS = 7'd55;  // 'A' minus ten

  // Map a digit value 0..15 to its upper-case ASCII code.
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] code;
    if (d < DIGIT_TEN) begin
      code = CH_ZERO + 7'(d);
    end else begin
      code = CH_LETTER_OFS + 7'(d);
    end
    return code;
  endfunction

endpackage

/* sv/r2a_front.sv */
module r2a_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  r2a_pkg::in_item_t     in_data,
  input  logic                  push,
  output logic                  full,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic [WORD_BITS-1:0]  q_mag,
  output logic                  q_neg,
  output logic [4:0]            q_base
);
  import r2a_pkg::*;

  localparam int QW = WORD_BITS + 6;

  logic [WORD_BITS-1:0] v;
  logic [WORD_BITS-1:0] mag;
  logic                 neg;
  logic [4:0]           base_c;

  logic [QW-1:0] q_mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  // Classify: clamp the radix, split off the sign, take the unsigned magnitude.
  always_comb begin
    v   = WORD_BITS'(in_data.value);
    neg = in_data.is_signed & v[WORD_BITS-1];
    mag = neg ? (~v + {{(WORD_BITS-1){1'b0}}, 1'b1}) : v;
    if (in_data.base < BASE_MIN) begin
      base_c = BASE_MIN;
    end else if (in_data.base > BASE_MAX) begin
      base_c = BASE_MAX;
    end else begin
      base_c = in_data.base;
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = q_pop & q_valid;

  assign {q_neg, q_base, q_mag} = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wp_r] <= {neg, base_c, mag};
    end
  end

endmodule

/* sv/r2a_conv.sv */
module r2a_conv #(
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  logic [WORD_BITS-1:0]              q_mag,
  input  logic                              q_neg,
  input  logic [4:0]                        q_base,
  output logic                              q_pop,
  output logic                              h_valid,
  input  logic                              h_take,
  output logic [4*WORD_BITS-1:0]            h_digits,
  output logic [$clog2(WORD_BITS+1)-1:0]    h_nd,
  output logic                              h_neg
);

  localparam int NC = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS + 1);
  localparam int KW = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_RUN  = 3'b010,
    CV_DONE = 3'b100
  } cv_state_t;

  cv_state_t            state_r, state_nxt;
  logic [WORD_BITS-1:0] mag_r;
  logic [4:0]           base_r;
  logic                 neg_r;
  logic [4*NC-1:0]      cells_r, cells_step;
  logic [CW-1:0]        nd_r;
  logic [KW-1:0]        cnt_r;
  logic [NC:0]          carry;
  logic [NC-1:0]        ge0, ge1;
  logic [4:0]           s;
  logic                 load;
  logic                 nd_inc;

  // Digit row: double every digit in the current radix and add the next
  // magnitude bit, propagating a carry from the lowest digit upward.
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      ge0[i] = ({cells_r[4*i +: 4], 1'b0} >= base_r);
      ge1[i] = ({cells_r[4*i +: 4], 1'b1} >= base_r);
    end
    carry[0] = mag_r[WORD_BITS-1];
    for (int i = 0; i < NC; i++) begin
      carry[i+1] = carry[i] ? ge1[i] : ge0[i];
    end
    cells_step = '0;
    s          = '0;
    for (int i = 0; i < NC; i++) begin
      s = {cells_r[4*i +: 4], carry[i]};
      cells_step[4*i +: 4] = carry[i+1] ? 4'(s - base_r) : s[3:0];
    end
  end

  // The top nonzero digit moves up by at most one place per bit.
  assign nd_inc = carry[nd_r] && (nd_r != CW'(NC));

  assign h_valid  = (state_r == CV_DONE);
  assign h_digits = cells_r;
  assign h_neg    = neg_r;
  assign h_nd     = (nd_r == '0) ? {{(CW-1){1'b0}}, 1'b1} : nd_r;

  always_comb begin
    load      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      CV_IDLE: begin
        if (q_valid) begin
          load      = 1'b1;
          state_nxt = CV_RUN;
        end
      end
      CV_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = CV_DONE;
        end
      end
      CV_DONE: begin
        if (h_take) begin
          if (q_valid) begin
            load      = 1'b1;
            state_nxt = CV_RUN;
          end else begin
            state_nxt = CV_IDLE;
          end
        end
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r   <= q_mag;
      base_r  <= q_base;
      neg_r   <= q_neg;
      cells_r <= '0;
      nd_r    <= '0;
      cnt_r   <= KW'(WORD_BITS - 1);
    end else if (state_r == CV_RUN) begin
      mag_r   <= mag_r << 1;
      cells_r <= cells_step;
      nd_r    <= nd_r + CW'(nd_inc);
      cnt_r   <= cnt_r - KW'(1);
    end
  end

endmodule

/* sv/r2a_emit.sv */
module r2a_emit #(
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              h_valid,
  input  logic [4*WORD_BITS-1:0]            h_digits,
  input  logic [$clog2(WORD_BITS+1)-1:0]    h_nd,
  input  logic                              h_neg,
  output logic                              h_take,
  output r2a_pkg::out_item_t                out_data,
  output logic                              empty,
  input  logic                              pop
);
  import r2a_pkg::*;

  localparam int NC = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS + 1);

  typedef enum logic [2:0] {
    EM_IDLE = 3'b001,
    EM_SIGN = 3'b010,
    EM_RUN  = 3'b100
  } em_state_t;

  em_state_t       state_r, state_nxt;
  logic [4*NC-1:0] row_r;
  logic [CW-1:0]   nd_r;
  logic [CW-1:0]   p_r;
  logic            ovalid_r, ovalid_nxt;
  out_item_t       out_r, out_nxt;
  logic            slot_free;
  logic            emit_here;
  logic            wr;
  logic            step;

  assign slot_free = !ovalid_r || pop;
  assign emit_here = (p_r < nd_r);
  assign h_take    = (state_r == EM_IDLE) && h_valid;

  always_comb begin
    state_nxt = state_r;
    wr        = 1'b0;
    step      = 1'b0;
    out_nxt   = out_r;
    case (state_r)
      EM_IDLE: begin
        if (h_valid) begin
          state_nxt = h_neg ? EM_SIGN : EM_RUN;
        end
      end
      EM_SIGN: begin
        if (slot_free) begin
          wr                 = 1'b1;
          out_nxt.digit_code = CH_MINUS;
          out_nxt.last       = 1'b0;
          state_nxt          = EM_RUN;
        end
      end
      EM_RUN: begin
        if (!emit_here || slot_free) begin
          step = 1'b1;
          if (emit_here) begin
            wr                 = 1'b1;
            out_nxt.digit_code = digit_char(row_r[4*NC-1 -: 4]);
            out_nxt.last       = (p_r == '0);
          end
          if (p_r == '0) begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
    ovalid_nxt = wr | (ovalid_r & ~pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= EM_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (h_take) begin
      row_r <= h_digits;
      nd_r  <= h_nd;
      p_r   <= CW'(WORD_BITS - 1);
    end else if (step) begin
      row_r <= row_r << 4;
      p_r   <= p_r - CW'(1);
    end
    if (wr) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;
  assign empty    = ~ovalid_r;

endmodule

/* sv/radix_integer_to_ascii.sv */
// Channel   Ports                          Direction  Transaction
// input     push, full, in_data            in         word, signed flag, radix
// result    empty, pop, out_data           out        one ASCII character, last flag
//
// Flow: the digit row converts one word, one magnitude bit per cycle, and then
// offers the finished row; the emitter takes the row and walks it top first,
// after a '-' for a negative word. The converter loads the next word as soon as
// the emitter has taken the row, so converting one word overlaps emitting the last.
// Reset: synchronous, active low; clears the input queue, both sequencers and
// the output valid. Stalls: pop low holds the character on out_data; a held
// emitter stalls the converter, which fills the two-entry queue and raises full.
module radix_integer_to_ascii #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  r2a_pkg::in_item_t   in_data,
  input  logic                push,
  output logic                full,
  output r2a_pkg::out_item_t  out_data,
  output logic                empty,
  input  logic                pop
);
  import r2a_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);

  // Queue between classifier and converter.
  logic                 q_valid;
  logic                 q_pop;
  logic [WORD_BITS-1:0] q_mag;
  logic                 q_neg;
  logic [4:0]           q_base;

  // Handoff of a finished digit row from converter to emitter.
  logic                   h_valid;
  logic                   h_take;
  logic [4*WORD_BITS-1:0] h_digits;
  logic [CW-1:0]          h_nd;
  logic                   h_neg;

  // Front: accept the transaction, clamp the radix, split sign and magnitude.
  r2a_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_mag   (q_mag),
    .q_neg   (q_neg),
    .q_base  (q_base)
  );

  // Back, first half: build the digits in the chosen radix, one bit per cycle.
  r2a_conv #(
    .WORD_BITS (WORD_BITS)
  ) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_mag    (q_mag),
    .q_neg    (q_neg),
    .q_base   (q_base),
    .q_pop    (q_pop),
    .h_valid  (h_valid),
    .h_take   (h_take),
    .h_digits (h_digits),
    .h_nd     (h_nd),
    .h_neg    (h_neg)
  );

  // Back, second half: drop leading zeros, emit sign and digits top first.
  r2a_emit #(
    .WORD_BITS (WORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .h_valid  (h_valid),
    .h_digits (h_digits),
    .h_nd     (h_nd),
    .h_neg    (h_neg),
    .h_take   (h_take),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import r2a_pkg::*;

  // Watchdog limit: cycles in a row with no transaction on either side.
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_WORDS = 234;
  localparam int CALM_WORDS = 40;
  localparam int MAX_REPORTS = 100;
  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_A = 7'h41;

  logic clk = 1'b0;
  logic rst_n;
  in_item_t in_data;
  logic push;
  logic full;
  out_item_t out_data;
  logic empty;
  logic pop;

  // Characters still owed by the block, oldest first.
  out_item_t pending_chars[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  // Random idling on both sides is allowed while this is set.
  bit idling_on = 1'b0;
  int pop_hold = 0;

  radix_integer_to_ascii uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_data(in_data),
    .push(push),
    .full(full),
    .out_data(out_data),
    .empty(empty),
    .pop(pop)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Expand one word into the characters it must produce: clamp the radix,
  // take the magnitude as unsigned, collect digits least significant first
  // and queue them most significant first, after a '-' for a negative word, with the last one marked.
  function automatic void predict_chars(input in_item_t word);
    logic [4:0] radix;
    logic [31:0] mag;
    logic negative;
    logic [3:0] d;
    logic [6:0] digits[$];
    out_item_t ch;
    radix = word.base;
    if (radix < 5'd2) begin
      radix = 5'd2;
    end else if (radix > 5'd16) begin
      radix = 5'd16;
    end
    negative = word.is_signed && word.value[31];
    mag = negative ? (~word.value + 32'd1) : word.value;
    do begin
      d = 4'(mag % 32'(radix));
      digits.push_front((d < 4'd10) ? ASCII_ZERO + 7'(d) : ASCII_A + 7'(d - 4'd10));
      mag = mag / 32'(radix);
    end while (mag != 32'd0);
    if (negative) begin
      ch.digit_code = CH_MINUS;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.digit_code = digits[i];
      ch.last = (i == digits.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Sample both channels at the rising edge. Check the popped character
  // first, then predict from an accepted word, so the order is fixed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h last=%0b with nothing pending",
                                    out_data.digit_code, out_data.last));
        end else begin
          if (out_data.digit_code !== pending_chars[0].digit_code) begin
            report_mismatch($sformatf("digit_code 0x%02h, predicted 0x%02h",
                                      out_data.digit_code, pending_chars[0].digit_code));
          end
          if (out_data.last !== pending_chars[0].last) begin
            report_mismatch($sformatf("last %0b, predicted %0b (char 0x%02h)",
                                      out_data.last, pending_chars[0].last,
                                      pending_chars[0].digit_code));
          end
          void'(pending_chars.pop_front());
        end
      end
      if (push && !full) begin
        predict_chars(in_data);
      end
      // Watchdog: count cycles with no transaction on either channel.
      if ((pop && !empty) || (push && !full)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Result side: pop is high out of reset except in random stall bursts while idling is on.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (rst_n && idling_on && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        pop_hold = $urandom_range(0, 3);
      end else begin
        pop <= rst_n;
      end
    end
  end

  // Offer one word and hold it until the block takes it. Called at a falling
  // edge; leaves push high unless an idle burst follows, so back-to-back
  // transactions never lower and raise push in the same step.
  task automatic send_word(input logic [31:0] value, input logic is_signed,
                           input logic [4:0] base);
    in_item_t word;
    word.value = value;
    word.is_signed = is_signed;
    word.base = base;
    in_data <= word;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Drop push and wait until every predicted character has come back.
  task automatic drain_chars();
    push <= 1'b0;
    do @(negedge clk); while (pending_chars.size() != 0);
  endtask

  // Zero, all ones, the most negative word and its neighbors. The most
  // negative word in binary gives the longest string: a sign and 32 digits.
  task automatic run_extremes();
    send_word(32'h0000_0000, 1'b0, 5'd10);
    send_word(32'h0000_0000, 1'b1, 5'd2);
    send_word(32'hFFFF_FFFF, 1'b0, 5'd2);
    send_word(32'hFFFF_FFFF, 1'b1, 5'd10);
    send_word(32'h8000_0000, 1'b1, 5'd2);
    send_word(32'h8000_0000, 1'b1, 5'd10);
    send_word(32'h8000_0000, 1'b0, 5'd16);
    send_word(32'h7FFF_FFFF, 1'b1, 5'd16);
  endtask

  // One word through every legal radix, both interpretations alternating.
  task automatic run_all_radixes();
    for (int r = 2; r <= 16; r++) begin
      send_word(32'hDEAD_BEEF, 1'(r[0]), 5'(r));
    end
  endtask

  // Radix codes outside 2..16 clamp to the nearest end.
  task automatic run_base_clamping();
    send_word(32'h0000_00FF, 1'b0, 5'd0);
    send_word(32'hFFFF_FF00, 1'b1, 5'd1);
    send_word(32'h1234_5678, 1'b0, 5'd17);
    send_word(32'hCAFE_F00D, 1'b1, 5'd31);
  endtask

  // Random words: a mix of small values, full-width values, values near the
  // signed and unsigned ends, and shifted values of every length. Idling comes
  // and goes in stretches, and the final words run with none at all.
  task automatic run_random_words();
    logic [31:0] value;
    logic [4:0] base;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idling_on = (n < RANDOM_WORDS - CALM_WORDS) && ((n / 30) % 3 != 2);
      case ($urandom_range(0, 5))
        0: value = $urandom_range(0, 40);
        1: value = 32'h8000_0000 + $urandom_range(0, 15);
        2: value = 32'hFFFF_FFFF - $urandom_range(0, 15);
        3: value = 32'h7FFF_FFFF - $urandom_range(0, 15);
        4: value = $urandom >> $urandom_range(0, 31);
        default: value = $urandom;
      endcase
      // Mostly legal radixes; now and then any 5-bit code.
      base = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(2, 16));
      send_word(value, 1'($urandom_range(0, 1)), base);
      // Hold off once mid-run until the block has emptied out.
      if (n == RANDOM_WORDS / 2) begin
        drain_chars();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_extremes();
    idling_on = 1'b1;
    run_all_radixes();
    run_base_clamping();
    // Let every directed character arrive before the random words start.
    drain_chars();
    run_random_words();

    drain_chars();
    // Allow a stray extra character to show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
